// ----- rtl/triangle_barycentric_coords_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define TBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbc assertion failed");
// Next-cycle implication, disabled in reset.
`define TBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbc assertion failed");
`endif

// ----- rtl/tbc_pkg.sv -----
// Shared constants, widths and types of the barycentric weight block.
package tbc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW  = 33;             // coordinate difference
  localparam int PW  = 2 * DW;         // product
  localparam int SW  = PW + 1;         // sum of two products
  localparam int MW  = SW - 1;         // magnitude of a sum
  localparam int RW  = MW + 1;         // divider remainder
  localparam int QW  = 33;             // quotient bits kept
  localparam int NSW = MW + FRAC_BITS; // scaled numerator
  localparam int HW  = NSW - QW;       // numerator bits above the quotient
  localparam logic [31:0] ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] THIRD = 32'(((64'd1 << FRAC_BITS) + 64'd1) / 3);

  localparam logic [1:0] FUNC_PLAIN = 2'd0;
  localparam logic [1:0] FUNC_SNAP  = 2'd1;
  localparam logic [1:0] FUNC_CLAMP = 2'd2;

  localparam logic CFG_SNAP_EPS = 1'b0;
  localparam logic CFG_DEGEN    = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic       contained;
    logic       coll;
    logic       neg1;
    logic       neg2;
    logic       ovf1;
    logic       ovf2;
  } side_t;
endpackage

// ----- rtl/tbc_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, two numerators.
module tbc_div_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [tbc_pkg::MW-1:0] in_d,
  input  logic [tbc_pkg::RW-1:0] in_rem1,
  input  logic [tbc_pkg::RW-1:0] in_rem2,
  input  logic [tbc_pkg::QW-1:0] in_lo1,
  input  logic [tbc_pkg::QW-1:0] in_lo2,
  input  tbc_pkg::side_t         in_side,
  output logic                  out_vld,
  output logic [tbc_pkg::QW-1:0] out_q1,
  output logic [tbc_pkg::QW-1:0] out_q2,
  output tbc_pkg::side_t         out_side
);
  import tbc_pkg::*;

  logic           vld_r  [QW];
  logic [MW-1:0]  d_r    [QW];
  logic [RW-1:0]  rem1_r [QW];
  logic [RW-1:0]  rem2_r [QW];
  logic [QW-1:0]  lo1_r  [QW];
  logic [QW-1:0]  lo2_r  [QW];
  logic [QW-1:0]  q1_r   [QW];
  logic [QW-1:0]  q2_r   [QW];
  side_t          side_r [QW];

  // One shift, compare and subtract step
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic b,
                                           input logic [MW-1:0] d);
    logic [RW-1:0] t;
    logic [RW-1:0] dx;
    t  = {rem[RW-2:0], b};
    dx = {{(RW-MW){1'b0}}, d};
    if (t >= dx) return {1'b1, t - dx};
    return {1'b0, t};
  endfunction

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < QW; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Advance the data, one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [RW:0] s1;
    logic [RW:0] s2;
    if (en) begin
      s1 = div_step(in_rem1, in_lo1[QW-1], in_d);
      s2 = div_step(in_rem2, in_lo2[QW-1], in_d);
      d_r[0]    <= in_d;
      rem1_r[0] <= s1[RW-1:0];
      rem2_r[0] <= s2[RW-1:0];
      lo1_r[0]  <= {in_lo1[QW-2:0], 1'b0};
      lo2_r[0]  <= {in_lo2[QW-2:0], 1'b0};
      q1_r[0]   <= {{(QW-1){1'b0}}, s1[RW]};
      q2_r[0]   <= {{(QW-1){1'b0}}, s2[RW]};
      side_r[0] <= in_side;
      for (int k = 1; k < QW; k++) begin
        s1 = div_step(rem1_r[k-1], lo1_r[k-1][QW-1], d_r[k-1]);
        s2 = div_step(rem2_r[k-1], lo2_r[k-1][QW-1], d_r[k-1]);
        d_r[k]    <= d_r[k-1];
        rem1_r[k] <= s1[RW-1:0];
        rem2_r[k] <= s2[RW-1:0];
        lo1_r[k]  <= {lo1_r[k-1][QW-2:0], 1'b0};
        lo2_r[k]  <= {lo2_r[k-1][QW-2:0], 1'b0};
        q1_r[k]   <= {q1_r[k-1][QW-2:0], s1[RW]};
        q2_r[k]   <= {q2_r[k-1][QW-2:0], s2[RW]};
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_q1   = q1_r[QW-1];
  assign out_q2   = q2_r[QW-1];
  assign out_side = side_r[QW-1];
endmodule

// ----- rtl/triangle_barycentric_coords.sv -----
// Barycentric weights of a point in a 2-D triangle, fully pipelined.
// Result path: stages 1 to 5, the quotient pipeline, then stages F1 and F2.
// Throughput: one word per cycle while the output is not stalled; the 33-stage quotient pipeline sets the depth.
// A stalled output freezes the whole pipeline; no word is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads
// snap_epsilon = 66 and degenerate_limit = 1.
module triangle_barycentric_coords (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_c_x,
  input  logic signed [31:0] in_c_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_weight_a,
  output logic signed [31:0] out_weight_b,
  output logic signed [31:0] out_weight_c,
  output logic               out_inside_res,
  output logic               out_collinear,
  output logic               out_saturated
);
  import tbc_pkg::*;

  logic        en;
  logic [16:0] snap_eps_r;
  logic [31:0] degen_r;

  function automatic logic signed [DW-1:0] sub33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] n;
    n = v[SW-1] ? -v : v;
    return n[MW-1:0];
  endfunction

  // Sign and saturate a quotient; bit 32 is the clip flag
  function automatic logic [32:0] sat_q(input logic neg, input logic ovf,
                                        input logic [QW-1:0] q);
    logic [QW-1:0] nq;
    nq = -q;
    if (!neg) begin
      if (ovf || q > {1'b0, 32'h7FFFFFFF}) return {1'b1, 32'h7FFFFFFF};
      return {1'b0, q[31:0]};
    end
    if (ovf || q > {1'b0, 32'h80000000}) return {1'b1, 32'h80000000};
    return {1'b0, nq[31:0]};
  endfunction

  function automatic logic [31:0] snapv(input logic [31:0] v, input logic [16:0] eps);
    logic [32:0] m;
    m = v[31] ? -{v[31], v} : {1'b0, v};
    return (m < {16'd0, eps}) ? 32'd0 : v;
  endfunction

  function automatic logic [31:0] clampv(input logic [31:0] v);
    if (v[31]) return 32'd0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  // ONE - a - b, clipped; bit 32 is the clip flag
  function automatic logic [32:0] third_w(input logic [31:0] a, input logic [31:0] b);
    logic signed [33:0] t;
    t = $signed({2'b00, ONE}) - $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
    if (t > $signed({2'b00, 32'h7FFFFFFF})) return {1'b1, 32'h7FFFFFFF};
    if (t < $signed({2'b11, 32'h80000000})) return {1'b1, 32'h80000000};
    return {1'b0, t[31:0]};
  endfunction

  // Hold the pipeline while the output word waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_eps_r <= 17'd66;
      degen_r    <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SNAP_EPS: snap_eps_r <= cfg_wdata[16:0];
        CFG_DEGEN:    degen_r    <= cfg_wdata;
        default:      degen_r    <= degen_r;
      endcase
    end
  end

  // Stage 1: coordinate differences
  logic                 v1_r;
  logic [1:0]           f1_r;
  logic signed [DW-1:0] bycy_r, axcx_r, cxbx_r, aycy_r, pxcx_r, pycy_r, cyay_r;
  logic signed [DW-1:0] pxax_r, pyay_r, bxax_r, byay_r, pxbx_r, pyby_r, cyby_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= in_func;
      bycy_r <= sub33(in_b_y, in_c_y);
      axcx_r <= sub33(in_a_x, in_c_x);
      cxbx_r <= sub33(in_c_x, in_b_x);
      aycy_r <= sub33(in_a_y, in_c_y);
      pxcx_r <= sub33(in_point_x, in_c_x);
      pycy_r <= sub33(in_point_y, in_c_y);
      cyay_r <= sub33(in_c_y, in_a_y);
      pxax_r <= sub33(in_point_x, in_a_x);
      pyay_r <= sub33(in_point_y, in_a_y);
      bxax_r <= sub33(in_b_x, in_a_x);
      byay_r <= sub33(in_b_y, in_a_y);
      pxbx_r <= sub33(in_point_x, in_b_x);
      pyby_r <= sub33(in_point_y, in_b_y);
      cyby_r <= sub33(in_c_y, in_b_y);
    end
  end

  // Stage 2: products
  logic                 v2_r;
  logic [1:0]           f2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [PW-1:0] c0a_r, c0b_r, c1a_r, c1b_r, c2a_r, c2b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r  <= f1_r;
      p0_r  <= bycy_r * axcx_r;
      p1_r  <= cxbx_r * aycy_r;
      p2_r  <= bycy_r * pxcx_r;
      p3_r  <= cxbx_r * pycy_r;
      p4_r  <= cyay_r * pxcx_r;
      p5_r  <= axcx_r * pycy_r;
      c0a_r <= pxax_r * byay_r;
      c0b_r <= pyay_r * bxax_r;
      c1a_r <= pxbx_r * cyby_r;
      c1b_r <= pyby_r * cxbx_r;
      c2a_r <= pxcx_r * aycy_r;
      c2b_r <= pycy_r * axcx_r;
    end
  end

  // Stage 3: sums and containment sign tests
  logic                 v3_r;
  logic [1:0]           f3_r;
  logic                 ins3_r;
  logic signed [SW-1:0] den_r, n1_r, n2_r;
  logic signed [SW-1:0] e0, e1, e2;

  always_comb begin
    e0 = SW'(c0a_r) - SW'(c0b_r);
    e1 = SW'(c1a_r) - SW'(c1b_r);
    e2 = SW'(c2a_r) - SW'(c2b_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r   <= f2_r;
      den_r  <= SW'(p0_r) + SW'(p1_r);
      n1_r   <= SW'(p2_r) + SW'(p3_r);
      n2_r   <= SW'(p4_r) + SW'(p5_r);
      ins3_r <= !e0[SW-1] && !e1[SW-1] && !e2[SW-1];
    end
  end

  // Stage 4: magnitudes, quotient signs, collinear test
  logic          v4_r;
  side_t         s4_r;
  logic [MW-1:0] dm4_r, nm1_r, nm2_r;

  always_ff @(posedge clk) begin
    logic [MW-1:0] dm;
    side_t         s;
    if (en) begin
      dm = mag(den_r);
      s.func      = f3_r;
      s.contained = ins3_r;
      s.coll      = (dm == '0) || (dm < {{(MW-32){1'b0}}, degen_r});
      s.neg1      = n1_r[SW-1] != den_r[SW-1];
      s.neg2      = n2_r[SW-1] != den_r[SW-1];
      s.ovf1      = 1'b0;
      s.ovf2      = 1'b0;
      dm4_r <= dm;
      nm1_r <= mag(n1_r);
      nm2_r <= mag(n2_r);
      s4_r  <= s;
    end
  end

  // Stage 5: scale numerators, detect quotient overflow, split for the divider
  logic          v5_r;
  side_t         s5_r;
  logic [MW-1:0] dm5_r;
  logic [RW-1:0] rem1_5_r, rem2_5_r;
  logic [QW-1:0] lo1_5_r, lo2_5_r;

  always_ff @(posedge clk) begin
    logic [NSW-1:0] ns1;
    logic [NSW-1:0] ns2;
    logic [RW-1:0]  h1;
    logic [RW-1:0]  h2;
    logic [RW-1:0]  dx;
    side_t          s;
    if (en) begin
      ns1 = {nm1_r, {FRAC_BITS{1'b0}}};
      ns2 = {nm2_r, {FRAC_BITS{1'b0}}};
      h1  = {{(RW-HW){1'b0}}, ns1[NSW-1:QW]};
      h2  = {{(RW-HW){1'b0}}, ns2[NSW-1:QW]};
      dx  = {{(RW-MW){1'b0}}, dm4_r};
      s      = s4_r;
      s.ovf1 = h1 >= dx;
      s.ovf2 = h2 >= dx;
      dm5_r    <= dm4_r;
      rem1_5_r <= h1;
      rem2_5_r <= h2;
      lo1_5_r  <= ns1[QW-1:0];
      lo2_5_r  <= ns2[QW-1:0];
      s5_r     <= s;
    end
  end

  // Advance valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Quotient pipeline
  logic          vd;
  logic [QW-1:0] q1, q2;
  side_t         sd;
  side_t         sd_in_w;

  assign sd_in_w = s5_r;

  tbc_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .in_d     (dm5_r),
    .in_rem1  (rem1_5_r),
    .in_rem2  (rem2_5_r),
    .in_lo1   (lo1_5_r),
    .in_lo2   (lo2_5_r),
    .in_side  (sd_in_w),
    .out_vld  (vd),
    .out_q1   (q1),
    .out_q2   (q2),
    .out_side (sd)
  );

  // Stage F1: sign, saturation, collinear weights
  logic        vf_r;
  logic [1:0]  ff_r;
  logic        insf_r, collf_r, satf_r;
  logic [31:0] l1f_r, l2f_r;

  always_ff @(posedge clk) begin
    logic [32:0] r1;
    logic [32:0] r2;
    if (en) begin
      r1 = sat_q(sd.neg1, sd.ovf1, q1);
      r2 = sat_q(sd.neg2, sd.ovf2, q2);
      ff_r    <= sd.func;
      insf_r  <= sd.contained;
      collf_r <= sd.coll;
      if (sd.coll) begin
        l1f_r  <= THIRD;
        l2f_r  <= THIRD;
        satf_r <= 1'b0;
      end else begin
        l1f_r  <= r1[31:0];
        l2f_r  <= r2[31:0];
        satf_r <= r1[32] || r2[32];
      end
    end
  end

  // Stage F2: mode step and third weight into the output register
  logic        out_valid_r;
  logic [31:0] wa_r, wb_r, wc_r;
  logic        ins_r, coll_r, sat_r;

  always_ff @(posedge clk) begin
    logic [31:0] a;
    logic [31:0] b;
    logic [32:0] c;
    if (en) begin
      case (ff_r)
        FUNC_SNAP: begin
          a = snapv(l1f_r, snap_eps_r);
          b = snapv(l2f_r, snap_eps_r);
          c = third_w(a, b);
          c[31:0] = snapv(c[31:0], snap_eps_r);
        end
        FUNC_CLAMP: begin
          a = clampv(l1f_r);
          b = clampv(l2f_r);
          c = third_w(a, b);
        end
        default: begin
          a = l1f_r;
          b = l2f_r;
          c = third_w(a, b);
        end
      endcase
      wa_r   <= a;
      wb_r   <= b;
      wc_r   <= c[31:0];
      ins_r  <= insf_r;
      coll_r <= collf_r;
      sat_r  <= satf_r || c[32];
    end
  end

  // Advance valid bits of the back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vf_r        <= vd;
      out_valid_r <= vf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_a   = wa_r;
  assign out_weight_b   = wb_r;
  assign out_weight_c   = wc_r;
  assign out_inside_res = ins_r;
  assign out_collinear  = coll_r;
  assign out_saturated  = sat_r;
endmodule

// ----- rtl/tbc_checker.sv -----
// Port-level checks of the barycentric weight block and their binding.
`include "triangle_barycentric_coords_assert.svh"
module tbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_weight_a,
  input logic signed [31:0] out_weight_b,
  input logic signed [31:0] out_weight_c,
  input logic               out_collinear,
  input logic               out_saturated
);
  // Hold a stalled result word
  `TBC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_weight_a) && $stable(out_weight_b) && $stable(out_weight_c))
  // Input ready follows the output side
  `TBC_ASSERT_NOW(a_ready, 1'b1, in_ready == (!out_valid || out_ready))
  // Collinear words carry equal first two weights
  `TBC_ASSERT_NOW(a_coll_eq, out_valid && out_collinear, out_weight_a == out_weight_b)
  // Collinear words never clip; checked only while in_valid is high
  `TBC_ASSERT_NOW(a_coll_sat, out_valid && out_collinear && in_valid, !out_saturated)
endmodule

bind triangle_barycentric_coords tbc_checker u_tbc_checker (.*);
